/* sv/rpa_pkg.sv */
package rpa_pkg;

  // Geometry of the managed memory.
  localparam int NUM_PAGES = 32768;
  localparam int PAGE_BITS = 12;
  localparam int IDX_W     = $clog2(NUM_PAGES);
  localparam int DEPTH_W   = $clog2(NUM_PAGES + 1);
  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 8;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd2;

  localparam logic [ADDR_W-1:0] BASE_ADDR_RST  = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] LOW_LIMIT_RST  = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] HIGH_LIMIT_RST = 32'h8800_0000;

  // Command codes.
  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_ADDREF = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  // Classified operation handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_ADDREF,
    OP_BAD,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
  } job_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] low_limit;
    logic [ADDR_W-1:0] high_limit;
  } cfg_t;

endpackage

/* sv/rpa_in_if.sv */
interface rpa_in_if;
  import rpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [ADDR_W-1:0] page_addr;

  modport source (output valid, output cmd, output page_addr, input ready);
  modport sink   (input valid, input cmd, input page_addr, output ready);

endinterface

/* sv/rpa_out_if.sv */
interface rpa_out_if;
  import rpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] alloc_addr;
  logic [CNT_W-1:0]  count_after;
  logic              page_released;

  modport source (output valid, output status, output alloc_addr, output count_after,
                  output page_released, input ready);
  modport sink   (input valid, input status, input alloc_addr, input count_after,
                  input page_released, output ready);

endinterface

/* sv/rpa_front.sv */
module rpa_front (
  rpa_in_if.sink        in_ch,
  input  rpa_pkg::cfg_t cfg,
  input  logic          clearing,
  input  logic          q_full,
  output logic          q_push,
  output rpa_pkg::job_t q_data
);
  import rpa_pkg::*;

  logic [ADDR_W-1:0] diff;
  logic [ADDR_W-1:0] page_off;
  logic              aligned;
  logic              in_window;
  logic              above_base;
  logic              in_pages;
  logic              addr_ok;

  // Address check: alignment, limit window, base and page count.
  always_comb begin
    diff       = in_ch.page_addr - cfg.base_addr;
    page_off   = diff >> PAGE_BITS;
    aligned    = (in_ch.page_addr[PAGE_BITS-1:0] == '0);
    in_window  = (in_ch.page_addr >= cfg.low_limit) && (in_ch.page_addr < cfg.high_limit);
    above_base = (in_ch.page_addr >= cfg.base_addr);
    in_pages   = (page_off < ADDR_W'(NUM_PAGES));
    addr_ok    = aligned && in_window && above_base && in_pages;
  end

  // Classify the command into a job for the back end.
  always_comb begin
    q_data.idx = IDX_W'(page_off);
    unique case (in_ch.cmd)
      CMD_ALLOC:  q_data.op = OP_ALLOC;
      CMD_FREE:   q_data.op = addr_ok ? OP_FREE : OP_BAD;
      CMD_ADDREF: q_data.op = addr_ok ? OP_ADDREF : OP_BAD;
      default:    q_data.op = OP_NOP;
    endcase
  end

  // No transfer is taken while the count memory is being cleared.
  assign in_ch.ready = !q_full && !clearing;
  assign q_push      = in_ch.valid && in_ch.ready;

endmodule

/* sv/rpa_queue.sv */
module rpa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rpa_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output rpa_pkg::job_t head,
  output logic          empty
);
  import rpa_pkg::*;

  // Two-entry circular queue of classified jobs.
  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign full  = (fill_r == 2'd2);
  assign empty = (fill_r == 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Payload slots carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/rpa_back.sv */
module rpa_back (
  input  logic          clk,
  input  logic          rst_n,
  input  rpa_pkg::cfg_t cfg,
  input  rpa_pkg::job_t head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          clearing,
  rpa_out_if.source     out_ch
);
  import rpa_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  // Memories: the reference counts and the free stack.
  logic [CNT_W-1:0] cnt_mem [NUM_PAGES];
  logic [IDX_W-1:0] stk_mem [NUM_PAGES];

  logic [1:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  op_t                op_r, op_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  logic               cnt_re, cnt_we;
  logic [IDX_W-1:0]   cnt_raddr, cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata, cnt_rdata_r;
  logic               stk_re, stk_we;
  logic [IDX_W-1:0]   stk_raddr, stk_waddr, stk_wdata, stk_rdata_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  logic [1:0]         res_status;
  logic [ADDR_W-1:0]  res_addr;
  logic [CNT_W-1:0]   res_count;
  logic               res_rel;
  logic [1:0]         out_status_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [CNT_W-1:0]   out_count_r;
  logic               out_rel_r;

  logic               out_free;
  logic [CNT_W-1:0]   cnt_dec, cnt_inc;
  logic [DEPTH_W-1:0] depth_dec;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign clearing  = (state_r == S_CLEAR);
  assign depth_dec = depth_r - DEPTH_W'(1);
  assign cnt_dec   = (cnt_rdata_r != '0) ? cnt_rdata_r - CNT_W'(1) : cnt_rdata_r;
  assign cnt_inc   = (cnt_rdata_r != CNT_MAX) ? cnt_rdata_r + CNT_W'(1) : cnt_rdata_r;

  // Sequencer: a clearing sweep after reset, then a memory read in S_ISSUE
  // and update plus result in S_EXEC, or a direct result from S_ISSUE.
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    depth_nxt  = depth_r;
    op_nxt     = op_r;
    idx_nxt    = idx_r;
    q_pop      = 1'b0;
    cnt_re     = 1'b0;
    cnt_raddr  = head.idx;
    cnt_we     = 1'b0;
    cnt_waddr  = idx_r;
    cnt_wdata  = '0;
    stk_re     = 1'b0;
    stk_raddr  = depth_dec[IDX_W-1:0];
    stk_we     = 1'b0;
    stk_waddr  = depth_r[IDX_W-1:0];
    stk_wdata  = idx_r;
    out_load   = 1'b0;
    res_status = ST_OK;
    res_addr   = '0;
    res_count  = '0;
    res_rel    = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        clr_nxt   = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(NUM_PAGES - 1)) begin
          state_nxt = S_ISSUE;
        end
      end

      S_ISSUE: begin
        if (!q_empty) begin
          op_nxt  = head.op;
          idx_nxt = head.idx;
          unique case (head.op)
            OP_ALLOC: begin
              if (depth_r != '0) begin
                q_pop     = 1'b1;
                stk_re    = 1'b1;
                depth_nxt = depth_dec;
                state_nxt = S_EXEC;
              end else if (out_free) begin
                q_pop      = 1'b1;
                out_load   = 1'b1;
                res_status = ST_EMPTY;
              end
            end
            OP_FREE, OP_ADDREF: begin
              q_pop     = 1'b1;
              cnt_re    = 1'b1;
              state_nxt = S_EXEC;
            end
            OP_BAD: begin
              if (out_free) begin
                q_pop      = 1'b1;
                out_load   = 1'b1;
                res_status = ST_BAD_ADDR;
              end
            end
            default: begin
              // Unused command: answered at once and changes nothing.
              if (out_free) begin
                q_pop    = 1'b1;
                out_load = 1'b1;
              end
            end
          endcase
        end
      end

      S_EXEC: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_ISSUE;
          unique case (op_r)
            OP_ALLOC: begin
              cnt_we    = 1'b1;
              cnt_waddr = stk_rdata_r;
              cnt_wdata = CNT_W'(1);
              res_addr  = cfg.base_addr + (ADDR_W'(stk_rdata_r) << PAGE_BITS);
              res_count = CNT_W'(1);
            end
            OP_FREE: begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_dec;
              res_count = cnt_dec;
              if (cnt_dec == '0) begin
                if (depth_r == DEPTH_W'(NUM_PAGES)) begin
                  res_status = ST_OVERFLOW;
                end else begin
                  stk_we    = 1'b1;
                  depth_nxt = depth_r + DEPTH_W'(1);
                  res_rel   = 1'b1;
                end
              end
            end
            default: begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_inc;
              res_count = cnt_inc;
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Job and result payload registers.
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    idx_r <= idx_nxt;
    if (out_load) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr;
      out_count_r  <= res_count;
      out_rel_r    <= res_rel;
    end
  end

  // Count memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata_r <= cnt_mem[cnt_raddr];
    end
  end

  // Free stack memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_r <= stk_mem[stk_raddr];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.alloc_addr    = out_addr_r;
  assign out_ch.count_after   = out_count_r;
  assign out_ch.page_released = out_rel_r;

endmodule

/* sv/refcounted_page_allocator.sv */
// Page allocator with a LIFO free stack of page indices and an 8-bit
// reference count per page, one result per command. After reset the count
// memory is cleared one page a cycle, all NUM_PAGES (32768) pages; no
// command transfer is taken until then, while configuration writes are.
// Free and add-reference that pass the address check, and an alloc on a
// non-empty stack, read memory in the back end's issue state, then update
// the memories and register the result in its execute state; a rejected
// address, an unused command or an alloc on an empty stack is answered in
// the issue state. A two-entry queue between the address checking front
// end and the back end lets the input keep transferring while a result waits.
module refcounted_page_allocator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [rpa_pkg::ADDR_W-1:0]            cfg_wdata,
  rpa_in_if.sink                                in_ch,
  rpa_out_if.source                             out_ch
);
  import rpa_pkg::*;

  cfg_t cfg_r;
  logic clearing;
  logic q_push, q_full, q_pop, q_empty;
  job_t q_data, q_head;

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_addr  <= BASE_ADDR_RST;
      cfg_r.low_limit  <= LOW_LIMIT_RST;
      cfg_r.high_limit <= HIGH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_BASE_ADDR:  cfg_r.base_addr  <= cfg_wdata;
        REG_LOW_LIMIT:  cfg_r.low_limit  <= cfg_wdata;
        REG_HIGH_LIMIT: cfg_r.high_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rpa_front u_front (
    .in_ch    (in_ch),
    .cfg      (cfg_r),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  rpa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  rpa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule

/* bench/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpa_pkg::*;

  localparam logic [1:0]        CMD_UNUSED      = 2'd3;
  localparam logic [ADDR_W-1:0] PAGE_SIZE       = 32'd1 << PAGE_BITS;
  localparam logic [ADDR_W-1:0] PAGE_MASK       = PAGE_SIZE - 32'd1;
  localparam int                WATCHDOG_LIMIT  = 100000;
  localparam int                LONG_HOLD       = 400;
  localparam int                DRAIN_CYCLES    = 8;
  localparam int                MAX_REPORTS     = 40;

  typedef struct {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] addr;
  } page_cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] alloc_addr;
    logic [CNT_W-1:0]  count_after;
    logic              page_released;
  } page_result_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [ADDR_W-1:0]    cfg_wdata = '0;

  rpa_in_if  in_ch ();
  rpa_out_if out_ch ();

  refcounted_page_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Commands waiting to be offered, and results owed by the block.
  page_cmd_t    pending_cmds[$];
  page_result_t awaited_results[$];

  // Shadow of the allocator: free stack, reference counts and registers.
  logic [IDX_W-1:0]  free_pages [NUM_PAGES];
  int unsigned       free_depth;
  logic [CNT_W-1:0]  page_refs [NUM_PAGES];
  logic [ADDR_W-1:0] base_reg;
  logic [ADDR_W-1:0] low_reg;
  logic [ADDR_W-1:0] high_reg;

  int gap_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_ack;
  int hold_left;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Translate an address into a page index, applying every range check.
  function automatic bit page_lookup(input logic [ADDR_W-1:0] addr,
                                     output logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] offset;
    idx = '0;
    if ((addr & PAGE_MASK) != 0) return 1'b0;
    if (addr < low_reg || addr >= high_reg) return 1'b0;
    if (addr < base_reg) return 1'b0;
    offset = (addr - base_reg) >> PAGE_BITS;
    if (offset >= NUM_PAGES) return 1'b0;
    idx = offset[IDX_W-1:0];
    return 1'b1;
  endfunction

  // Apply one command to the shadow state and return the result it owes.
  function automatic page_result_t apply_page_cmd(input logic [1:0] cmd,
                                                  input logic [ADDR_W-1:0] addr);
    page_result_t      r;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] wide_idx;
    r = '0;
    case (cmd)
      CMD_ALLOC: begin
        if (free_depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          free_depth--;
          idx = free_pages[free_depth[IDX_W-1:0]];
          page_refs[idx] = 8'd1;
          wide_idx = ADDR_W'(idx);
          r.alloc_addr = base_reg + (wide_idx << PAGE_BITS);
          r.count_after = 8'd1;
        end
      end
      CMD_FREE: begin
        if (!page_lookup(addr, idx)) begin
          r.status = ST_BAD_ADDR;
        end else begin
          if (page_refs[idx] != 0) page_refs[idx]--;
          r.count_after = page_refs[idx];
          // A zero count goes back on the stack, double frees included.
          if (page_refs[idx] == 0) begin
            if (free_depth >= NUM_PAGES) begin
              r.status = ST_OVERFLOW;
            end else begin
              free_pages[free_depth[IDX_W-1:0]] = idx;
              free_depth++;
              r.page_released = 1'b1;
            end
          end
        end
      end
      CMD_ADDREF: begin
        if (!page_lookup(addr, idx)) begin
          r.status = ST_BAD_ADDR;
        end else begin
          if (page_refs[idx] != CNT_MAX) page_refs[idx]++;
          r.count_after = page_refs[idx];
        end
      end
      default: begin
        // The unused command leaves everything alone and answers OK.
      end
    endcase
    return r;
  endfunction

  // Address of page k under the current base, rounded up to a page boundary.
  function automatic logic [ADDR_W-1:0] pool_addr(input int k);
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] wide_k;
    first = (base_reg + PAGE_MASK) & ~PAGE_MASK;
    wide_k = k;
    return first + (wide_k << PAGE_BITS);
  endfunction

  task automatic queue_cmd(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr);
    page_cmd_t c;
    c.cmd = cmd;
    c.addr = addr;
    pending_cmds.push_back(c);
  endtask

  task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Register write through the configuration port; the shadow follows it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BASE_ADDR:  base_reg = val;
      REG_LOW_LIMIT:  low_reg = val;
      REG_HIGH_LIMIT: high_reg = val;
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  // Wait until every command has been transferred and answered.
  task automatic wait_until_drained();
    while (pending_cmds.size() != 0 || in_ch.valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed traffic over a small pool of pages, with some noise.
  task automatic queue_random_cmds(input int n_items, input int pool_n);
    int                issued;
    int                r;
    int                k;
    int                burst;
    logic [ADDR_W-1:0] stray;
    @(negedge clk);
    // Start-up: hand every pool page to the allocator once.
    for (k = 0; k < pool_n; k++) queue_cmd(CMD_FREE, pool_addr(k));
    issued = 0;
    while (issued < n_items) begin
      r = $urandom_range(99);
      k = ($urandom_range(15) == 0) ? NUM_PAGES - 1 : $urandom_range(pool_n - 1);
      if (r < 28) begin
        queue_cmd(CMD_ALLOC, $urandom());
      end else if (r < 52) begin
        queue_cmd(CMD_FREE, pool_addr(k));
      end else if (r < 74) begin
        queue_cmd(CMD_ADDREF, pool_addr(k));
      end else if (r < 78) begin
        queue_cmd(CMD_UNUSED, $urandom());
      end else if (r < 93) begin
        // Addresses on and around the edges of the accepted range.
        case ($urandom_range(7))
          0: stray = $urandom();
          1: stray = high_reg;
          2: stray = high_reg - PAGE_SIZE;
          3: stray = low_reg;
          4: stray = low_reg - PAGE_SIZE;
          5: stray = pool_addr(k) | $urandom_range(PAGE_MASK, 1);
          6: stray = pool_addr(NUM_PAGES);
          default: stray = base_reg - PAGE_SIZE;
        endcase
        queue_cmd($urandom_range(1) ? CMD_FREE : CMD_ADDREF, stray);
      end else begin
        // A run of allocations, often enough to empty the stack.
        burst = $urandom_range(12, 4);
        repeat (burst) queue_cmd(CMD_ALLOC, $urandom());
        issued += burst - 1;
      end
      issued++;
    end
  endtask

  // Input driver: offers the next pending command, with random gaps.
  always @(posedge clk) begin
    page_cmd_t c;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= '0;
      in_ch.page_addr <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct) begin
        c = pending_cmds.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= c.cmd;
        in_ch.page_addr <= c.addr;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_ack <= 1'b0;
      hold_left <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Predict on each command transfer, compare on each result transfer.
  always @(posedge clk) begin
    page_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        awaited_results.push_back(apply_page_cmd(in_ch.cmd, in_ch.page_addr));
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $error("result transfer with no command awaiting it, status %0d",
                   out_ch.status);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", ADDR_W'(want.status), ADDR_W'(out_ch.status));
          check_field("alloc_addr", want.alloc_addr, out_ch.alloc_addr);
          check_field("count_after", ADDR_W'(want.count_after),
                      ADDR_W'(out_ch.count_after));
          check_field("page_released", ADDR_W'(want.page_released),
                      ADDR_W'(out_ch.page_released));
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.page_addr = '0;
    out_ch.ready = 1'b0;
    foreach (page_refs[i]) page_refs[i] = '0;
    free_depth = 0;
    base_reg = BASE_ADDR_RST;
    low_reg = LOW_LIMIT_RST;
    high_reg = HIGH_LIMIT_RST;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty stack, the end pages, LIFO order, rejected addresses,
    // the unused command, a double free, then emptying the stack again.
    queue_cmd(CMD_ALLOC, 32'hFFFF_FFFF);
    queue_cmd(CMD_FREE, pool_addr(0));
    queue_cmd(CMD_FREE, pool_addr(NUM_PAGES - 1));
    queue_cmd(CMD_FREE, pool_addr(5));
    queue_cmd(CMD_ADDREF, pool_addr(0));
    queue_cmd(CMD_ALLOC, 32'h0);
    queue_cmd(CMD_ADDREF, pool_addr(5));
    queue_cmd(CMD_FREE, pool_addr(5));
    queue_cmd(CMD_FREE, pool_addr(5));
    queue_cmd(CMD_FREE, base_reg + 32'd1);
    queue_cmd(CMD_FREE, high_reg);
    queue_cmd(CMD_ADDREF, low_reg - PAGE_SIZE);
    queue_cmd(CMD_ADDREF, 32'hFFFF_FFFF);
    queue_cmd(CMD_FREE, 32'h0);
    queue_cmd(CMD_UNUSED, 32'hFFFF_FFFF);
    queue_cmd(CMD_UNUSED, 32'h0);
    queue_cmd(CMD_FREE, pool_addr(0));
    queue_cmd(CMD_FREE, pool_addr(0));
    repeat (6) queue_cmd(CMD_ALLOC, $urandom());
    wait_until_drained();

    // Reset settings, no idling, with one page driven into saturation.
    queue_random_cmds(180, 16);
    repeat (258) queue_cmd(CMD_ADDREF, pool_addr(3));
    repeat (2) queue_cmd(CMD_FREE, pool_addr(3));
    wait_until_drained();

    // Widest window at address zero; the sender idles.
    write_reg(REG_BASE_ADDR, 32'h0);
    write_reg(REG_LOW_LIMIT, 32'h0);
    write_reg(REG_HIGH_LIMIT, 32'hFFFF_FFFF);
    gap_pct = 75;
    stall_pct = 0;
    queue_random_cmds(180, 16);
    wait_until_drained();

    // Highest page-aligned base, so allocated addresses wrap; receiver stalls.
    write_reg(REG_BASE_ADDR, 32'hFFFF_F000);
    write_reg(REG_LOW_LIMIT, 32'hFFFF_F000);
    gap_pct = 0;
    stall_pct = 75;
    queue_random_cmds(180, 4);
    wait_until_drained();

    // Unaligned base inside a narrower window; both sides idle.
    write_reg(REG_BASE_ADDR, 32'h1234_5678);
    write_reg(REG_LOW_LIMIT, 32'h1000_0000);
    write_reg(REG_HIGH_LIMIT, 32'h2000_0000);
    gap_pct = 27;
    stall_pct = 27;
    queue_random_cmds(180, 16);
    wait_until_drained();

    // Low limit above the base; the receiver holds off for a long stretch
    // while commands keep coming, then the sender waits for every result.
    write_reg(REG_BASE_ADDR, 32'h4000_0000);
    write_reg(REG_LOW_LIMIT, 32'h4001_0000);
    write_reg(REG_HIGH_LIMIT, 32'h4010_0000);
    gap_pct = 0;
    stall_pct = 0;
    hold_req = ~hold_req;
    queue_random_cmds(160, 32);
    wait_until_drained();
    stall_pct = 75;
    queue_random_cmds(60, 32);
    wait_until_drained();

    // Empty window: every free and add-reference is refused.
    write_reg(REG_LOW_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_HIGH_LIMIT, 32'h0);
    gap_pct = 27;
    stall_pct = 27;
    queue_random_cmds(30, 8);
    wait_until_drained();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
